/* rtl/zts_pkg.sv */
// Package for the Z-order tile swizzle block: mode and register codes,
// stream widths and the constant depth-conversion tables.
// No dependencies.
`default_nettype none

package zts_pkg;

	// Fixed widths of the stream and configuration fields.
	localparam int PIX_W     = 32;
	localparam int IDX_W     = 16;
	localparam int SIDE_W    = 8;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 8;

	// Default maximum image side in pixels.
	localparam int MAX_SIDE_DEF = 248;

	// Tile geometry: 8x8 tiles, 64 pixels walked in Morton order.
	localparam int TILE_PIX_W = 6;

	// Conversion modes.
	typedef enum logic [MODE_W-1:0] {
		MODE_565_TO_RGBA = 2'd0,
		MODE_RGBA_TO_565 = 2'd1,
		MODE_565_TO_ABGR = 2'd2,
		MODE_ABGR_TO_565 = 2'd3
	} mode_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 8'd1;

	// Reset values of the registers.
	localparam logic [SIDE_W-1:0] SIDE_RESET = 8'd8;

	// Table types for the depth conversions.
	typedef logic [7:0] lut5to8_t [32];
	typedef logic [7:0] lut6to8_t [64];
	typedef logic [4:0] lut8to5_t [256];
	typedef logic [5:0] lut8to6_t [256];

	// floor(c * out_max / in_max) by repeated subtraction; used only to
	// build the constant tables at elaboration.
	function automatic int unsigned scale_floor(int unsigned c, int unsigned out_max,
			int unsigned in_max);
		int unsigned n;
		int unsigned q;
		n = c * out_max;
		q = 0;
		for (int k = 0; k < 256; k++) begin
			if (n >= in_max) begin
				n = n - in_max;
				q = q + 1;
			end
		end
		return q;
	endfunction

	function automatic lut5to8_t build_5to8();
		lut5to8_t t;
		for (int i = 0; i < 32; i++) begin
			t[i] = 8'(scale_floor(i, 255, 31));
		end
		return t;
	endfunction

	function automatic lut6to8_t build_6to8();
		lut6to8_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = 8'(scale_floor(i, 255, 63));
		end
		return t;
	endfunction

	function automatic lut8to5_t build_8to5();
		lut8to5_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = 5'(scale_floor(i, 31, 255));
		end
		return t;
	endfunction

	function automatic lut8to6_t build_8to6();
		lut8to6_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = 6'(scale_floor(i, 63, 255));
		end
		return t;
	endfunction

	localparam lut5to8_t LUT_5TO8 = build_5to8();
	localparam lut6to8_t LUT_6TO8 = build_6to8();
	localparam lut8to5_t LUT_8TO5 = build_8to5();
	localparam lut8to6_t LUT_8TO6 = build_8to6();

endpackage

`default_nettype wire

/* rtl/zorder_tile_swizzle_rgb565.sv */
// Z-order tile swizzle with RGB565 <-> 32-bit color conversion, top level.
// Depends on zts_pkg for codes, widths and the conversion tables.
//
// Usage: pixels arrive on the input channel (in_valid, in_stall, pixel_in)
// in tiled order: 8x8 tiles row by row, Morton order inside a tile. For
// each pixel one result leaves on the output channel (out_valid,
// out_stall) with the converted color, the row-major index, the index in
// the tiled stream and a flag on the last pixel of the image.
// An accepted pixel is registered in the input stage and then in the output
// register before out_valid rises for its result.
// The pixel passes one input stage that snapshots the traversal position,
// then the output register where the color tables and the y*side+x product
// are resolved. Throughput is one pixel per cycle while out_stall is low;
// the position counters advance once per accepted pixel.
// When the receiver stalls, the output register holds its transaction and
// the input stage still takes one more pixel; in_stall rises only when both
// stages are full. Configuration writes (cfg_valid, cfg_ready, cfg_index,
// cfg_data) are always taken and belong to idle periods; a write to either
// register restarts the traversal, and an index past the list is ignored.
// Reset sets mode 0, side 8 and clears the traversal and both stages; no
// clearing pass is needed.
`default_nettype none

module zorder_tile_swizzle_rgb565 #(
	parameter int MAX_SIDE = zts_pkg::MAX_SIDE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration write channel.
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [zts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [zts_pkg::CFG_DAT_W-1:0] cfg_data,
	// Pixel input channel.
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [zts_pkg::PIX_W-1:0]     pixel_in,
	// Result channel.
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [zts_pkg::PIX_W-1:0]          pixel_out,
	output logic [zts_pkg::IDX_W-1:0]          linear_index,
	output logic [zts_pkg::IDX_W-1:0]          tiled_index,
	output logic                               last_pixel
);
	import zts_pkg::*;

	// Tile counter widths follow from the largest side.
	localparam int MAX_TILES = MAX_SIDE / 8;
	localparam int TILE_W    = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int TCNT_W    = $clog2(MAX_TILES + 1);
	localparam int COORD_W   = TILE_W + 3;
	localparam int PROD_W    = COORD_W + SIDE_W;
	localparam int SIDE_CAP  = MAX_TILES * 8;

	// Configuration registers and traversal state.
	mode_t                  mode_q;
	logic [SIDE_W-1:0]      side_q;
	logic [TILE_W-1:0]      col_q;
	logic [TILE_W-1:0]      row_q;
	logic [TILE_PIX_W-1:0]  wt_q;
	logic [IDX_W-1:0]       seq_q;

	// Input stage.
	logic                   valid_s1;
	logic [PIX_W-1:0]       pixel_s1;
	mode_t                  mode_s1;
	logic [SIDE_W-1:0]      side_s1;
	logic [TILE_W-1:0]      col_s1;
	logic [TILE_W-1:0]      row_s1;
	logic [TILE_PIX_W-1:0]  wt_s1;
	logic [IDX_W-1:0]       seq_s1;
	logic                   last_s1;

	// Output stage.
	logic                   valid_s2;
	logic [PIX_W-1:0]       pixel_s2;
	logic [IDX_W-1:0]       lin_s2;
	logic [IDX_W-1:0]       seq_s2;
	logic                   last_s2;

	logic                   cfg_we;
	logic                   cfg_hit;
	logic                   in_acc;
	logic                   adv;
	logic [SIDE_W-1:0]      eff_side;
	logic [TCNT_W-1:0]      eff_tiles;
	logic                   tile_end;
	logic                   col_end;
	logic                   row_end;
	logic                   last_now;

	logic [2:0]             sx;
	logic [2:0]             sy;
	logic [COORD_W-1:0]     x_c;
	logic [COORD_W-1:0]     y_c;
	logic [PROD_W-1:0]      prod;
	logic [IDX_W-1:0]       lin_c;
	logic [PIX_W-1:0]       color_c;

	// Handshakes. Only a write to a listed register restarts the walk.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;
	assign cfg_hit   = cfg_we & ((cfg_index == CFG_MODE) | (cfg_index == CFG_SIDE));
	assign adv       = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall  = valid_s1 & valid_s2 & out_stall;
	assign in_acc    = in_valid & ~in_stall;

	// Effective side: low bits dropped, clamped to [8, SIDE_CAP].
	always_comb begin
		eff_side = {side_q[SIDE_W-1:3], 3'b000};
		if (eff_side < SIDE_W'(8)) begin
			eff_side = SIDE_W'(8);
		end
		if (eff_side > SIDE_W'(SIDE_CAP)) begin
			eff_side = SIDE_W'(SIDE_CAP);
		end
		eff_tiles = TCNT_W'(eff_side >> 3);
	end

	// End-of-tile, end-of-row and end-of-image conditions.
	assign tile_end = (wt_q == {TILE_PIX_W{1'b1}});
	assign col_end  = ((TCNT_W + 1)'(col_q) + (TCNT_W + 1)'(1)) >= (TCNT_W + 1)'(eff_tiles);
	assign row_end  = ((TCNT_W + 1)'(row_q) + (TCNT_W + 1)'(1)) >= (TCNT_W + 1)'(eff_tiles);
	assign last_now = tile_end & col_end & row_end;

	// Configuration registers and traversal counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_565_TO_RGBA;
			side_q <= SIDE_RESET;
			col_q  <= '0;
			row_q  <= '0;
			wt_q   <= '0;
			seq_q  <= '0;
		end else if (cfg_hit) begin
			if (cfg_index == CFG_MODE) begin
				mode_q <= mode_t'(cfg_data[MODE_W-1:0]);
			end else if (cfg_index == CFG_SIDE) begin
				side_q <= cfg_data[SIDE_W-1:0];
			end
			col_q <= '0;
			row_q <= '0;
			wt_q  <= '0;
			seq_q <= '0;
		end else if (in_acc) begin
			if (tile_end) begin
				wt_q <= '0;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + TILE_W'(1);
				end else begin
					col_q <= col_q + TILE_W'(1);
				end
			end else begin
				wt_q <= wt_q + TILE_PIX_W'(1);
			end
			seq_q <= last_now ? '0 : seq_q + IDX_W'(1);
		end
	end

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload: pixel and a snapshot of the traversal position.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pixel_s1 <= pixel_in;
			mode_s1  <= mode_q;
			side_s1  <= eff_side;
			col_s1   <= col_q;
			row_s1   <= row_q;
			wt_s1    <= wt_q;
			seq_s1   <= seq_q;
			last_s1  <= last_now;
		end
	end

	// Morton de-interleave and row-major index.
	assign sx    = {wt_s1[4], wt_s1[2], wt_s1[0]};
	assign sy    = {wt_s1[5], wt_s1[3], wt_s1[1]};
	assign x_c   = {col_s1, sx};
	assign y_c   = {row_s1, sy};
	assign prod  = PROD_W'(y_c) * PROD_W'(side_s1);
	assign lin_c = IDX_W'(prod + PROD_W'(x_c));

	// Color conversion through the constant depth tables.
	always_comb begin
		unique case (mode_s1)
			MODE_565_TO_RGBA: begin
				color_c = {8'hFF, LUT_5TO8[pixel_s1[15:11]],
					LUT_6TO8[pixel_s1[10:5]], LUT_5TO8[pixel_s1[4:0]]};
			end
			MODE_565_TO_ABGR: begin
				color_c = {LUT_5TO8[pixel_s1[4:0]], LUT_6TO8[pixel_s1[10:5]],
					LUT_5TO8[pixel_s1[15:11]], 8'hFF};
			end
			MODE_RGBA_TO_565: begin
				color_c = {16'h0000, LUT_8TO5[pixel_s1[23:16]],
					LUT_8TO6[pixel_s1[15:8]], LUT_8TO5[pixel_s1[7:0]]};
			end
			MODE_ABGR_TO_565: begin
				color_c = {16'h0000, LUT_8TO5[pixel_s1[7:0]],
					LUT_8TO6[pixel_s1[15:8]], LUT_8TO5[pixel_s1[23:16]]};
			end
			default: begin
				color_c = '0;
			end
		endcase
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_s2 <= color_c;
			lin_s2   <= lin_c;
			seq_s2   <= seq_s1;
			last_s2  <= last_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign pixel_out    = pixel_s2;
	assign linear_index = lin_s2;
	assign tiled_index  = seq_s2;
	assign last_pixel   = last_s2;

	// The last pixel sits at the bottom-right corner, where both indexes meet.
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && last_s2 |-> lin_s2 == seq_s2)
		else $error("last pixel indexes disagree");

	// Inside a tile the Morton position steps by one per accepted pixel.
	a_wt_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !cfg_hit && !tile_end |=> wt_q == $past(wt_q) + TILE_PIX_W'(1))
		else $error("within-tile position did not advance");

	// A zero stream position means the traversal is at the image origin.
	a_seq_origin: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == '0 |-> wt_q == '0 && col_q == '0 && row_q == '0)
		else $error("stream position and traversal out of step");

	// A full input stage with a free output register must move forward.
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> valid_s2)
		else $error("input stage failed to advance");

endmodule

`default_nettype wire

/* verif/tb_zorder_tile_swizzle_rgb565.sv */
// Testbench for zorder_tile_swizzle_rgb565: drives pixels in tiled order and
// checks color, linear index, tiled index and end-of-image flag per pixel.
// Depends on zts_pkg and the zorder_tile_swizzle_rgb565 RTL.
`default_nettype none

module tb_zorder_tile_swizzle_rgb565;
	timeunit 1ns;
	timeprecision 1ps;

	import zts_pkg::*;

	localparam int RANDOM_PIXELS  = 1050;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 4;

	// Corner colors: all zero, all one, unused upper bits only, single
	// channel maxima and mixed byte patterns.
	localparam logic [31:0] CORNER_PIX [6] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_0000,
		32'hFFFF_0000, 32'h0000_07E0, 32'h00FF_80FF
	};
	localparam mode_t ALL_MODES [4] = '{
		MODE_565_TO_RGBA, MODE_RGBA_TO_565, MODE_565_TO_ABGR, MODE_ABGR_TO_565
	};

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_style_t;

	typedef struct packed {
		logic [PIX_W-1:0] color;
		logic [IDX_W-1:0] linear;
		logic [IDX_W-1:0] tiled;
		logic             last;
	} tile_pixel_t;

	// Tracks the traversal position and color mode, and holds the pixels
	// the block still owes, oldest first.
	class tile_walk_checker;
		mode_t         mode;
		logic [7:0]    side;
		int unsigned   tile_col;
		int unsigned   tile_row;
		int unsigned   tile_pos;
		logic [15:0]   seq_count;
		tile_pixel_t   owed_pixels [$];
		int            errors;

		function new();
			mode = MODE_565_TO_RGBA;
			side = SIDE_RESET;
			errors = 0;
			restart();
		endfunction

		function void restart();
			tile_col = 0;
			tile_row = 0;
			tile_pos = 0;
			seq_count = '0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			if (idx == CFG_MODE) begin
				mode = mode_t'(data[MODE_W-1:0]);
				restart();
			end else if (idx == CFG_SIDE) begin
				side = data;
				restart();
			end
		endfunction

		function int unsigned side_in_use();
			int unsigned s;
			int unsigned cap;
			s = side & 8'hF8;
			cap = MAX_SIDE_DEF & 'hF8;
			if (cap < 8) cap = 8;
			if (s < 8) s = 8;
			if (s > cap) s = cap;
			return s;
		endfunction

		function int unsigned rescale(int unsigned c, int unsigned from_max,
				int unsigned to_max);
			return (c * to_max) / from_max;
		endfunction

		function logic [PIX_W-1:0] convert_color(logic [PIX_W-1:0] pix);
			logic [7:0] r8, g8, b8;
			logic [4:0] r5, b5;
			logic [5:0] g6;
			case (mode)
				MODE_565_TO_RGBA, MODE_565_TO_ABGR: begin
					r8 = 8'(rescale(pix[4:0], 31, 255));
					g8 = 8'(rescale(pix[10:5], 63, 255));
					b8 = 8'(rescale(pix[15:11], 31, 255));
					if (mode == MODE_565_TO_RGBA)
						return {8'hFF, b8, g8, r8};
					return {r8, g8, b8, 8'hFF};
				end
				MODE_RGBA_TO_565: begin
					r5 = 5'(rescale(pix[7:0], 255, 31));
					g6 = 6'(rescale(pix[15:8], 255, 63));
					b5 = 5'(rescale(pix[23:16], 255, 31));
				end
				default: begin
					r5 = 5'(rescale(pix[23:16], 255, 31));
					g6 = 6'(rescale(pix[15:8], 255, 63));
					b5 = 5'(rescale(pix[7:0], 255, 31));
				end
			endcase
			return {16'h0000, b5, g6, r5};
		endfunction

		// Works out the result of one accepted pixel and steps the walk.
		function void note_pixel(logic [PIX_W-1:0] pix);
			tile_pixel_t want;
			int unsigned s, tiles, x, y;
			logic [5:0] w;
			s = side_in_use();
			tiles = s >> 3;
			w = 6'(tile_pos);
			x = tile_col * 8 + {w[4], w[2], w[0]};
			y = tile_row * 8 + {w[5], w[3], w[1]};
			want.color = convert_color(pix);
			want.linear = IDX_W'(y * s + x);
			want.tiled = seq_count;
			want.last = (tile_pos >= 63) && (tile_col + 1 >= tiles) && (tile_row + 1 >= tiles);
			owed_pixels.push_back(want);

			if (tile_pos >= 63) begin
				tile_pos = 0;
				if (tile_col + 1 >= tiles) begin
					tile_col = 0;
					tile_row = (tile_row + 1 >= tiles) ? 0 : tile_row + 1;
				end else begin
					tile_col = tile_col + 1;
				end
			end else begin
				tile_pos = tile_pos + 1;
			end
			seq_count = want.last ? 16'h0000 : seq_count + 16'h0001;
		endfunction

		task report(string field, logic [31:0] got, logic [31:0] want);
			$display("%0t: %s mismatch, got %0h, expected %0h", $time, field, got, want);
			errors++;
		endtask

		task check_pixel(tile_pixel_t got);
			tile_pixel_t want;
			if (owed_pixels.size() == 0) begin
				report("unexpected result", got.color, '0);
				return;
			end
			want = owed_pixels.pop_front();
			if (got.color !== want.color) report("pixel_out", got.color, want.color);
			if (got.linear !== want.linear)
				report("linear_index", 32'(got.linear), 32'(want.linear));
			if (got.tiled !== want.tiled)
				report("tiled_index", 32'(got.tiled), 32'(want.tiled));
			if (got.last !== want.last)
				report("last_pixel", 32'(got.last), 32'(want.last));
		endtask

		function int owed();
			return owed_pixels.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [PIX_W-1:0]     pixel_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [PIX_W-1:0]     pixel_out;
	logic [IDX_W-1:0]     linear_index;
	logic [IDX_W-1:0]     tiled_index;
	logic                 last_pixel;

	tile_walk_checker chk = new();
	int               pixels_sent = 0;
	int               idle_cycles = 0;
	stall_style_t     stall_style = STALL_NONE;
	logic [7:0]       stall_tick = '0;

	zorder_tile_swizzle_rgb565 dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_in     (pixel_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_out    (pixel_out),
		.linear_index (linear_index),
		.tiled_index  (tiled_index),
		.last_pixel   (last_pixel)
	);

	always #6 clk = ~clk;

	// Every transaction on the three channels is seen here, before the
	// edge updates anything.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				chk.write_register(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				chk.note_pixel(pixel_in);
			if (out_valid && !out_stall)
				chk.check_pixel({pixel_out, linear_index, tiled_index, last_pixel});
		end
	end

	// Receiver backpressure: a new stall style each time the 8-bit stall_tick wraps to zero.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 8'd1;
		if (stall_tick == 8'd0)
			stall_style <= stall_style_t'($urandom_range(0, 3));
		case (stall_style)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
			STALL_HEAVY:    out_stall <= ($urandom_range(0, 99) < 70);
			STALL_PERIODIC: out_stall <= (stall_tick[2:0] < 3'd3);
		endcase
	end

	// Ends the run when nothing moves on any channel for too long.
	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_zorder_tile_swizzle_rgb565: FAIL");
			$finish;
		end
	end

	// One register write, after which the write channel is left idle before the task returns.
	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task send_pixel(logic [PIX_W-1:0] pix);
		in_valid <= 1'b1;
		pixel_in <= pix;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pixels_sent++;
	endtask

	// Waits until every owed pixel has come out and the pipe has settled.
	task drain();
		@(posedge clk);
		while (chk.owed() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sends random pixels in bursts, or as one steady stream.
	task send_phase(int count);
		int left;
		int burst;
		bit steady;
		steady = ($urandom_range(0, 3) == 0);
		left = count;
		while (left > 0) begin
			burst = steady ? left : $urandom_range(1, 16);
			if (burst > left) burst = left;
			repeat (burst) send_pixel($urandom());
			left -= burst;
			if (left > 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	// Side values weighted toward small images, with the clamped and
	// unaligned cases mixed in.
	function logic [7:0] pick_side();
		case ($urandom_range(0, 9))
			0:       return 8'd0;
			1:       return 8'd7;
			2, 3:    return 8'd8;
			4:       return 8'd16;
			5:       return 8'd255;
			6:       return 8'd248;
			7:       return 8'(8 * $urandom_range(3, 30) + $urandom_range(0, 7));
			8:       return 8'd12;
			default: return 8'd249;
		endcase
	endfunction

	initial begin
		logic [7:0]  side_val;
		int unsigned span;
		int          count;
		bit          first_phase;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: corner colors in every mode at the reset side.
		foreach (ALL_MODES[m]) begin
			drain();
			write_reg(CFG_MODE, 8'(ALL_MODES[m]));
			foreach (CORNER_PIX[k]) send_pixel(CORNER_PIX[k]);
			in_valid <= 1'b0;
		end

		// Random phases; the first one walks a whole 8x8 image and wraps.
		first_phase = 1'b1;
		while (pixels_sent < RANDOM_PIXELS) begin
			drain();
			side_val = first_phase ? 8'd0 : pick_side();
			if ($urandom_range(0, 1)) begin
				write_reg(CFG_MODE, 8'($urandom()));
				write_reg(CFG_SIDE, side_val);
			end else begin
				write_reg(CFG_SIDE, side_val);
				write_reg(CFG_MODE, 8'($urandom()));
			end
			// Writes past the register list must leave the walk alone.
			if ($urandom_range(0, 3) == 0)
				write_reg(8'($urandom_range(CFG_SIDE + 1, 255)), 8'($urandom()));
			span = side_val & 8'hF8;
			if (span < 8) span = 8;
			if (span <= 16)
				count = span * span + $urandom_range(0, 70);
			else
				count = $urandom_range(30, 150);
			if (count > RANDOM_PIXELS - pixels_sent)
				count = RANDOM_PIXELS - pixels_sent;
			send_phase(count);
			first_phase = 1'b0;
		end

		@(posedge clk);
		while (chk.owed() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (chk.errors == 0)
			$display("tb_zorder_tile_swizzle_rgb565: PASS");
		else
			$display("tb_zorder_tile_swizzle_rgb565: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
